// ===== design/mer_pkg.sv =====
// Shared widths, command codes and the plot descriptor for the midpoint ellipse rasterizer.
// No dependencies; imported by every module in design/.
package mer_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;

    localparam int POS_BITS   = RADIUS_BITS + 1;           // cur_x / cur_y
    localparam int PIX_BITS   = COORD_BITS + 2;            // pixel coordinates
    localparam int SQ_BITS    = 2 * RADIUS_BITS;           // rx^2, ry^2
    localparam int ARG_BITS   = RADIUS_BITS + 2;           // x+1, 2x+1, 2y-1, y-1
    localparam int ARG_SQ     = 2 * ARG_BITS;              // squared test argument
    localparam int PROD_BITS  = SQ_BITS + ARG_SQ;          // multiplier output
    localparam int SUM_BITS   = PROD_BITS + 3;             // midpoint test sums
    localparam int SLOPE_BITS = SQ_BITS + POS_BITS + 1;    // 2*ry^2*x, 2*rx^2*y

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [1:0] QUAD_FIRST = 2'd0;
    localparam logic [1:0] QUAD_LAST  = 2'd3;

    // One plotted point, expanded into four quadrant pixels by the emitter
    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [POS_BITS-1:0]   x;
        logic [POS_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
        logic                  fin;
    } t_plot;

endpackage

// ===== design/midpoint_ellipse_raster_core.sv =====
// Midpoint ellipse rasterizer, one shared multiplier under a small sequencer.
// Start request: radius precompute (rx^2, ry^2, slope, 4rx^2ry^2) in S_SQ_RX..S_RHS_WR overlapped
// with emitting 4 pixels; the next request is not taken until both are done.
// Step request: S_U, S_BU, S_V, S_AV, S_CMP, then 4 pixels at one per cycle unless the output stalls.
// The single multiplier sets the step latency. Synchronous active-low reset goes idle.
module midpoint_ellipse_raster_core
    import mer_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [COORD_BITS-1:0]      i_center_x,
    input  logic [COORD_BITS-1:0]      i_center_y,
    input  logic [RADIUS_BITS-1:0]     i_radius_x,
    input  logic [RADIUS_BITS-1:0]     i_radius_y,
    input  logic [COLOR_BITS-1:0]      i_color,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [PIX_BITS-1:0] o_pixel_x,
    output logic signed [PIX_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0]      o_pixel_color,
    output logic                       o_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RX,
        S_SQ_RY,
        S_SLOPE,
        S_RHS,
        S_RHS_WR,
        S_U,
        S_BU,
        S_V,
        S_AV,
        S_CMP
    } t_state;

    t_state                 r_state;
    logic                   r_active;
    logic                   r_second;
    logic                   r_reg1;
    logic [POS_BITS-1:0]    r_x;
    logic [POS_BITS-1:0]    r_y;
    logic [SLOPE_BITS-1:0]  r_slope_x;
    logic [SLOPE_BITS-1:0]  r_slope_y;
    logic [COORD_BITS-1:0]  r_cx;
    logic [COORD_BITS-1:0]  r_cy;
    logic [RADIUS_BITS-1:0] r_rx;
    logic [RADIUS_BITS-1:0] r_ry;
    logic [COLOR_BITS-1:0]  r_color;
    logic [SQ_BITS-1:0]     r_a2;
    logic [SQ_BITS-1:0]     r_b2;
    logic [SUM_BITS-1:0]    r_rhs;
    logic [PROD_BITS-1:0]   r_t;

    logic                   w_accept;
    logic                   w_emit_busy;
    logic                   w_emit_start;
    t_plot                  w_plot;
    logic [SQ_BITS-1:0]     w_mul_a;
    logic [ARG_SQ-1:0]      w_mul_b;
    logic [PROD_BITS-1:0]   w_prod;
    logic [ARG_BITS-1:0]    w_u;
    logic [ARG_BITS-1:0]    w_v;
    logic [SUM_BITS-1:0]    w_lhs;
    logic                   w_move_y;
    logic                   w_move_x;
    logic [POS_BITS-1:0]    n_x;
    logic [POS_BITS-1:0]    n_y;
    logic [SLOPE_BITS-1:0]  n_slope_x;
    logic [SLOPE_BITS-1:0]  n_slope_y;

    assign o_in_stall = (r_state != S_IDLE) || w_emit_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Midpoint test arguments: region one uses x+1 and 2y-1, region two 2x+1 and y-1
    assign w_u = r_reg1 ? (ARG_BITS'(r_x) + ARG_BITS'(1)) : ARG_BITS'({r_x, 1'b1});
    assign w_v = r_reg1 ? (ARG_BITS'({r_y, 1'b0}) - ARG_BITS'(1))
                        : (ARG_BITS'(r_y) - ARG_BITS'(1));

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SQ_RX: begin
                w_mul_a = SQ_BITS'(r_rx);
                w_mul_b = ARG_SQ'(r_rx);
            end
            S_SQ_RY: begin
                w_mul_a = SQ_BITS'(r_ry);
                w_mul_b = ARG_SQ'(r_ry);
            end
            S_SLOPE: begin
                w_mul_a = r_a2;
                w_mul_b = ARG_SQ'(r_ry);
            end
            S_RHS: begin
                w_mul_a = r_a2;
                w_mul_b = ARG_SQ'(r_b2);
            end
            S_U: begin
                w_mul_a = SQ_BITS'(w_u);
                w_mul_b = ARG_SQ'(w_u);
            end
            S_BU: begin
                w_mul_a = r_b2;
                w_mul_b = w_prod[ARG_SQ-1:0];
            end
            S_V: begin
                w_mul_a = SQ_BITS'(w_v);
                w_mul_b = ARG_SQ'(w_v);
            end
            S_AV: begin
                w_mul_a = r_a2;
                w_mul_b = w_prod[ARG_SQ-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mer_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // In S_CMP, r_t holds ry^2*u^2 and w_prod holds rx^2*v^2
    always_comb begin
        if (r_reg1) begin
            w_lhs    = (SUM_BITS'(r_t) << 2) + SUM_BITS'(w_prod);
            w_move_y = w_lhs > r_rhs;
            w_move_x = 1'b1;
        end else begin
            w_lhs    = SUM_BITS'(r_t) + (SUM_BITS'(w_prod) << 2);
            w_move_x = w_lhs < r_rhs;
            w_move_y = 1'b1;
        end
        n_x       = w_move_x ? (r_x + POS_BITS'(1)) : r_x;
        n_y       = w_move_y ? (r_y - POS_BITS'(1)) : r_y;
        n_slope_x = w_move_x ? (r_slope_x + SLOPE_BITS'({r_b2, 1'b0})) : r_slope_x;
        n_slope_y = w_move_y ? (r_slope_y - SLOPE_BITS'({r_a2, 1'b0})) : r_slope_y;
    end

    assign w_emit_start = (w_accept && (i_cmd == CMD_START)) || (r_state == S_CMP);

    always_comb begin
        if (r_state == S_CMP) begin
            w_plot.cx    = r_cx;
            w_plot.cy    = r_cy;
            w_plot.x     = n_x;
            w_plot.y     = n_y;
            w_plot.color = r_color;
            w_plot.fin   = (n_y == '0);
        end else begin
            w_plot.cx    = i_center_x;
            w_plot.cy    = i_center_y;
            w_plot.x     = '0;
            w_plot.y     = POS_BITS'(i_radius_y);
            w_plot.color = i_color;
            w_plot.fin   = (i_radius_y == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_second <= 1'b0;
            r_reg1   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_cmd == CMD_START) begin
                            r_cx      <= i_center_x;
                            r_cy      <= i_center_y;
                            r_rx      <= i_radius_x;
                            r_ry      <= i_radius_y;
                            r_color   <= i_color;
                            r_x       <= '0;
                            r_y       <= POS_BITS'(i_radius_y);
                            r_slope_x <= '0;
                            r_second  <= 1'b0;
                            r_active  <= (i_radius_y != '0);
                            r_state   <= S_SQ_RX;
                        end else if (r_active) begin
                            // latch region two once the slope crosses over
                            if (!r_second && (r_slope_x < r_slope_y)) begin
                                r_reg1 <= 1'b1;
                            end else begin
                                r_reg1   <= 1'b0;
                                r_second <= 1'b1;
                            end
                            r_state <= S_U;
                        end
                    end
                end
                S_SQ_RX: begin
                    r_state <= S_SQ_RY;
                end
                S_SQ_RY: begin
                    r_a2    <= w_prod[SQ_BITS-1:0];
                    r_state <= S_SLOPE;
                end
                S_SLOPE: begin
                    r_b2    <= w_prod[SQ_BITS-1:0];
                    r_state <= S_RHS;
                end
                S_RHS: begin
                    r_slope_y <= {w_prod[SLOPE_BITS-2:0], 1'b0};
                    r_state   <= S_RHS_WR;
                end
                S_RHS_WR: begin
                    r_rhs   <= SUM_BITS'(w_prod) << 2;
                    r_state <= S_IDLE;
                end
                S_U: begin
                    r_state <= S_BU;
                end
                S_BU: begin
                    r_state <= S_V;
                end
                S_V: begin
                    r_t     <= w_prod;
                    r_state <= S_AV;
                end
                S_AV: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_x       <= n_x;
                    r_y       <= n_y;
                    r_slope_x <= n_slope_x;
                    r_slope_y <= n_slope_y;
                    if (n_y == '0) begin
                        r_active <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mer_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_emit_start),
        .i_plot        (w_plot),
        .o_busy        (w_emit_busy),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

endmodule

// ===== design/mer_mul.sv =====
// Shared registered multiplier used by the ellipse sequencer for every square and product.
// Depends on mer_pkg for operand and product widths.
module mer_mul
    import mer_pkg::*;
(
    input  logic                 i_clk,
    input  logic [SQ_BITS-1:0]   i_a,
    input  logic [ARG_SQ-1:0]    i_b,
    output logic [PROD_BITS-1:0] o_prod
);

    logic [PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_BITS'(i_a) * PROD_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/mer_emit.sv =====
// Quadrant pixel emitter: expands one plot into four pixels through an output register.
// Depends on mer_pkg for t_plot and coordinate widths.
module mer_emit
    import mer_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  t_plot                      i_plot,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [PIX_BITS-1:0] o_pixel_x,
    output logic signed [PIX_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0]      o_pixel_color,
    output logic                       o_last
);

    t_plot                r_plot;
    logic                 r_busy;
    logic                 r_valid;
    logic [1:0]           r_k;
    logic [PIX_BITS-1:0]  r_px;
    logic [PIX_BITS-1:0]  r_py;
    logic [COLOR_BITS-1:0] r_color;
    logic                 r_last;

    logic                 w_free;
    logic [PIX_BITS-1:0]  w_xp, w_xm, w_yp, w_ym;

    assign w_free = !r_valid || !i_stall;

    // Coordinates wrap modulo 2^PIX_BITS
    assign w_xp = PIX_BITS'(r_plot.cx) + PIX_BITS'(r_plot.x);
    assign w_xm = PIX_BITS'(r_plot.cx) - PIX_BITS'(r_plot.x);
    assign w_yp = PIX_BITS'(r_plot.cy) + PIX_BITS'(r_plot.y);
    assign w_ym = PIX_BITS'(r_plot.cy) - PIX_BITS'(r_plot.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_k     <= QUAD_FIRST;
        end else begin
            if (i_start) begin
                r_plot <= i_plot;
                r_busy <= 1'b1;
                r_k    <= QUAD_FIRST;
            end
            if (w_free) begin
                if (r_busy) begin
                    // quadrant order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
                    r_valid <= 1'b1;
                    r_px    <= r_k[0] ? w_xm : w_xp;
                    r_py    <= r_k[1] ? w_ym : w_yp;
                    r_color <= r_plot.color;
                    r_last  <= r_plot.fin && (r_k == QUAD_LAST);
                    r_k     <= r_k + 2'd1;
                    if (r_k == QUAD_LAST) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_valid <= 1'b0;
                end
            end
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_last        = r_last;

endmodule

// ===== tb/sv/midpoint_ellipse_pixel_check.sv =====
// Pixel checker for the midpoint ellipse rasterizer: watches both handshakes,
// predicts the quadrant pixels of every accepted request and compares them in order.
// Depends on mer_pkg for the port widths and the command codes.
module midpoint_ellipse_pixel_check
    import mer_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_cmd,
    input  logic [COORD_BITS-1:0]      i_center_x,
    input  logic [COORD_BITS-1:0]      i_center_y,
    input  logic [RADIUS_BITS-1:0]     i_radius_x,
    input  logic [RADIUS_BITS-1:0]     i_radius_y,
    input  logic [COLOR_BITS-1:0]      i_color,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [PIX_BITS-1:0] i_pixel_x,
    input  logic signed [PIX_BITS-1:0] i_pixel_y,
    input  logic [COLOR_BITS-1:0]      i_pixel_color,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_pixel_count,
    output int                         o_ellipse_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] px;
        logic signed [PIX_BITS-1:0] py;
        logic [COLOR_BITS-1:0]      color;
        logic                       fin;
    } t_pixel;

    t_pixel expected_pixels[$];

    // Rasterizer state as the predictor sees it
    logic                   drawing;
    logic                   in_region_two;
    logic [POS_BITS-1:0]    pos_x;
    logic [POS_BITS-1:0]    pos_y;
    longint unsigned        slope_x;
    longint unsigned        slope_y;
    logic [COORD_BITS-1:0]  ctr_x;
    logic [COORD_BITS-1:0]  ctr_y;
    logic [RADIUS_BITS-1:0] rad_x;
    logic [RADIUS_BITS-1:0] rad_y;
    logic [COLOR_BITS-1:0]  ink;

    // Queue the four quadrant pixels of the current point
    task automatic queue_plot();
        longint unsigned xp;
        longint unsigned xm;
        longint unsigned yp;
        longint unsigned ym;
        logic            on_axis_end;
        t_pixel          p;
        xp = longint'(ctr_x) + longint'(pos_x);
        xm = longint'(ctr_x) - longint'(pos_x);
        yp = longint'(ctr_y) + longint'(pos_y);
        ym = longint'(ctr_y) - longint'(pos_y);
        on_axis_end = (pos_y == '0);
        p.color = ink;
        p.fin   = 1'b0;
        p.px = xp[PIX_BITS-1:0];
        p.py = yp[PIX_BITS-1:0];
        expected_pixels.push_back(p);
        p.px = xm[PIX_BITS-1:0];
        expected_pixels.push_back(p);
        p.px = xp[PIX_BITS-1:0];
        p.py = ym[PIX_BITS-1:0];
        expected_pixels.push_back(p);
        p.px  = xm[PIX_BITS-1:0];
        p.fin = on_axis_end;
        expected_pixels.push_back(p);
        if (on_axis_end) begin
            drawing = 1'b0;
        end
    endtask

    task automatic rasterize_request(
        input logic                   cmd,
        input logic [COORD_BITS-1:0]  cx,
        input logic [COORD_BITS-1:0]  cy,
        input logic [RADIUS_BITS-1:0] rx,
        input logic [RADIUS_BITS-1:0] ry,
        input logic [COLOR_BITS-1:0]  color
    );
        longint unsigned a2;
        longint unsigned b2;
        longint unsigned arg_x;
        longint unsigned arg_y;
        longint unsigned lhs;
        longint unsigned rhs;
        if (cmd == CMD_START) begin
            ctr_x = cx;
            ctr_y = cy;
            rad_x = rx;
            rad_y = ry;
            ink   = color;
            pos_x = '0;
            pos_y = POS_BITS'(ry);
            slope_x = 0;
            slope_y = 2 * longint'(rx) * longint'(rx) * longint'(ry);
            in_region_two = 1'b0;
            drawing = 1'b1;
            queue_plot();
        end else if (drawing) begin
            a2  = longint'(rad_x) * longint'(rad_x);
            b2  = longint'(rad_y) * longint'(rad_y);
            rhs = 4 * a2 * b2;
            if (!in_region_two && slope_x < slope_y) begin
                // Region one: x always advances, y drops when the midpoint is outside
                arg_x = longint'(pos_x) + 1;
                arg_y = 2 * longint'(pos_y) - 1;
                lhs = 4 * b2 * arg_x * arg_x + a2 * arg_y * arg_y;
                if (lhs > rhs) begin
                    pos_y   = pos_y - 1'b1;
                    slope_y = slope_y - 2 * a2;
                end
                slope_x = slope_x + 2 * b2;
                pos_x   = arg_x[POS_BITS-1:0];
            end else begin
                // Region two: y always drops, x advances when the midpoint is inside
                in_region_two = 1'b1;
                arg_x = 2 * longint'(pos_x) + 1;
                arg_y = longint'(pos_y) - 1;
                lhs = b2 * arg_x * arg_x + 4 * a2 * arg_y * arg_y;
                if (lhs < rhs) begin
                    pos_x   = pos_x + 1'b1;
                    slope_x = slope_x + 2 * b2;
                end
                slope_y = slope_y - 2 * a2;
                pos_y   = arg_y[POS_BITS-1:0];
            end
            queue_plot();
        end
    endtask

    task automatic report_field(input string name, input longint want_v, input longint got_v);
        o_fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel want;
        if (!i_rst_n) begin
            drawing       = 1'b0;
            in_region_two = 1'b0;
            pos_x   = '0;
            pos_y   = '0;
            slope_x = 0;
            slope_y = 0;
            ctr_x   = '0;
            ctr_y   = '0;
            rad_x   = RADIUS_BITS'(1);
            rad_y   = RADIUS_BITS'(1);
            ink     = '0;
            expected_pixels.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                rasterize_request(i_cmd, i_center_x, i_center_y, i_radius_x, i_radius_y,
                                  i_color);
            end
            if (i_out_valid && !i_out_stall) begin
                o_pixel_count++;
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected pixel, expected none, actual (%0d, %0d)",
                             $time, i_pixel_x, i_pixel_y);
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_x !== want.px) begin
                        report_field("pixel_x", want.px, i_pixel_x);
                    end
                    if (i_pixel_y !== want.py) begin
                        report_field("pixel_y", want.py, i_pixel_y);
                    end
                    if (i_pixel_color !== want.color) begin
                        report_field("pixel_color", want.color, i_pixel_color);
                    end
                    if (i_last !== want.fin) begin
                        report_field("last", want.fin, i_last);
                    end
                    if (want.fin) begin
                        o_ellipse_count++;
                    end
                end
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ===== tb/sv/midpoint_ellipse_raster_core_test.sv =====
// Top of the rasterizer testbench: clock, reset, request stimulus and output stalls.
// Instantiates midpoint_ellipse_raster_core and midpoint_ellipse_pixel_check; uses mer_pkg.
module midpoint_ellipse_raster_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mer_pkg::*;

    localparam int RANDOM_REQS  = 210;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_cmd     = CMD_START;
    logic [COORD_BITS-1:0]      in_cx      = '0;
    logic [COORD_BITS-1:0]      in_cy      = '0;
    logic [RADIUS_BITS-1:0]     in_rx      = RADIUS_BITS'(1);
    logic [RADIUS_BITS-1:0]     in_ry      = RADIUS_BITS'(1);
    logic [COLOR_BITS-1:0]      in_color   = '0;
    logic                       out_stall  = 1'b0;
    logic                       in_stall;
    logic                       out_valid;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]      pixel_color;
    logic                       pixel_last;

    int   fail_count;
    int   pending;
    int   pixel_count;
    int   ellipse_count;
    int   send_idle_pct  = 31;
    int   recv_stall_pct = 46;
    logic hold_request   = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   cycle_count    = 0;
    int   total_reqs     = 0;
    int   start_reqs     = 0;

    midpoint_ellipse_raster_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (in_cmd),
        .i_center_x    (in_cx),
        .i_center_y    (in_cy),
        .i_radius_x    (in_rx),
        .i_radius_y    (in_ry),
        .i_color       (in_color),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_color (pixel_color),
        .o_last        (pixel_last)
    );

    midpoint_ellipse_pixel_check u_pixel_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (in_cmd),
        .i_center_x      (in_cx),
        .i_center_y      (in_cy),
        .i_radius_x      (in_rx),
        .i_radius_y      (in_ry),
        .i_color         (in_color),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_pixel_x       (pixel_x),
        .i_pixel_y       (pixel_y),
        .i_pixel_color   (pixel_color),
        .i_last          (pixel_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_pixel_count   (pixel_count),
        .o_ellipse_count (ellipse_count)
    );

    always begin
        #10ns clk = 1'b1;
        #10ns clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles, %0d pixels still expected",
                     $time, cycle_count, pending);
            $display("** midpoint_ellipse_raster_core: FAILED **");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_req(
        input logic                   cmd,
        input logic [COORD_BITS-1:0]  cx,
        input logic [COORD_BITS-1:0]  cy,
        input logic [RADIUS_BITS-1:0] rx,
        input logic [RADIUS_BITS-1:0] ry,
        input logic [COLOR_BITS-1:0]  color
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_cx    <= cx;
        in_cy    <= cy;
        in_rx    <= rx;
        in_ry    <= ry;
        in_color <= color;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        total_reqs++;
    endtask

    // Step requests carry random payload, which the block must ignore
    task automatic send_step();
        send_req(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                 RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), COLOR_BITS'($urandom));
    endtask

    task automatic draw_ellipse(
        input logic [COORD_BITS-1:0]  cx,
        input logic [COORD_BITS-1:0]  cy,
        input logic [RADIUS_BITS-1:0] rx,
        input logic [RADIUS_BITS-1:0] ry,
        input logic [COLOR_BITS-1:0]  color,
        input int                     steps
    );
        send_req(CMD_START, cx, cy, rx, ry, color);
        start_reqs++;
        repeat (steps) begin
            send_step();
        end
    endtask

    initial begin : stimulus
        int kind;
        int steps;
        int phase;
        int drain;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle step, smallest ellipse, extreme corners, abandoned drawings
        send_step();
        draw_ellipse('0, '0, RADIUS_BITS'(1), RADIUS_BITS'(1), '0, 2);
        draw_ellipse('1, '1, '1, '1, '1, 3);
        draw_ellipse('0, '0, '1, '1, 24'h5A5A5A, 2);
        draw_ellipse(COORD_BITS'(100), COORD_BITS'(200), RADIUS_BITS'(3), RADIUS_BITS'(1),
                     24'h00FF00, 5);
        draw_ellipse(COORD_BITS'(300), COORD_BITS'(50), RADIUS_BITS'(1), RADIUS_BITS'(4),
                     24'h0000FF, 6);

        // Random: mostly complete small ellipses, some abandoned, some huge, some noise
        while (total_reqs < RANDOM_REQS) begin
            phase = total_reqs * 3 / RANDOM_REQS;
            case (phase)
                0: begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 46;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 31;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request  <= 1'b1;
                end
            endcase
            kind = $urandom_range(0, 9);
            rx = RADIUS_BITS'($urandom_range(1, 12));
            ry = RADIUS_BITS'($urandom_range(1, 12));
            if (kind == 9) begin
                send_step();
            end else begin
                if (kind == 8) begin
                    rx = RADIUS_BITS'($urandom_range(1, 1023));
                    ry = RADIUS_BITS'($urandom_range(1, 1023));
                    steps = $urandom_range(1, 6);
                end else if (kind == 7) begin
                    steps = $urandom_range(0, rx + ry - 1);
                end else begin
                    // run past the end so a trailing step or two hits an idle block
                    steps = rx + ry + 1 + $urandom_range(0, 1);
                end
                draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry,
                             COLOR_BITS'($urandom), steps);
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests with %0d ellipse starts, stalls and a long hold-off.",
                 total_reqs, start_reqs);
        $display("Checked %0d pixels; %0d ellipses reached their last pixel, %0d left over.",
                 pixel_count, ellipse_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("** midpoint_ellipse_raster_core: PASSED **");
        end else begin
            $display("** midpoint_ellipse_raster_core: FAILED **");
        end
        $finish;
    end

endmodule
